// File: rtl/grpc_unary_deframer_defines.svh
// assertion macros for the deframer
`ifndef GRPC_UNARY_DEFRAMER_DEFINES_SVH
`define GRPC_UNARY_DEFRAMER_DEFINES_SVH

// same-cycle implication
`define GUD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GUD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/gud_pkg.sv
`timescale 1ns / 1ps
package gud_pkg;

    localparam int HEADER_BYTES   = 5;
    localparam int FLAG_COMP_BIT  = 0;
    localparam int FLAG_TRLR_BIT  = 7;

    typedef enum logic [1:0] {
        KIND_DATA       = 2'd0,
        KIND_COMPRESSED = 2'd1,
        KIND_TRAILER    = 2'd2,
        KIND_EXTRA      = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_TRUNC_HEADER  = 3'd1,
        ST_TRUNC_MESSAGE = 3'd2,
        ST_COMPRESSED    = 3'd3,
        ST_EXTRA         = 3'd4,
        ST_NONE          = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'b01,
        PH_PAYLOAD = 2'b10
    } phase_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       byte_valid;
        logic       end_of_body;
    } in_item_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic       body_done;
        logic [2:0] status;
    } out_item_t;

endpackage

// File: rtl/gud_stream_if.sv
`timescale 1ns / 1ps
interface gud_in_if;
    import gud_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gud_out_if;
    import gud_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/grpc_unary_deframer.sv
`timescale 1ns / 1ps
// length-prefixed message deframer for a unary response body
// body channel: one transfer per item, a body byte (byte_valid) and/or an
//   end marker (end_of_body); a transfer happens when valid and ready are high
// result channel: one transfer per data payload byte and one closing transfer
//   per body carrying body_done and the status code; items that produce
//   nothing (header bytes, non-data payload bytes, bytes after an error, empty transfers) send nothing
// path: a body item is registered in the input register, then its result in the
//   result register; an untaken result in the result register holds it back
// throughput: one body item per clock unless a result waits in the result
//   register; the only loop is the frame state (phase, header count, 32-bit
//   length countdown) updated once per item
// stall: while a result waits in the result register the input register
//   holds its item, so at most two items sit in the block; body ready stays
//   high while the input register is empty or moving on
// reset: rst_n low clears the pipeline valids and all frame state, so the
//   next item starts a new body; the closing transfer of a body also returns
//   the frame state to its reset value
module grpc_unary_deframer (
    input  logic       clk,
    input  logic       rst_n,
    gud_in_if.sink     body,
    gud_out_if.source  result
);
    import gud_pkg::*;

    `include "grpc_unary_deframer_defines.svh"

    // input register
    logic     s1_valid_reg;
    in_item_t s1_item_reg;

    // result register
    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg, out_item_next;

    // frame state
    phase_t      phase_reg, phase_next;
    logic [2:0]  hdr_count_reg, hdr_count_next;
    logic [7:0]  flags_reg, flags_next;
    logic [31:0] remaining_reg, remaining_next;
    kind_t       kind_reg, kind_next;
    logic        seen_reg, seen_next;
    status_t     err_reg, err_next;

    logic    advance;
    logic    proc;
    logic    pass;
    status_t st;

    // input register moves on when the result register can take its result
    assign advance    = !out_valid_reg || result.ready;
    assign proc       = s1_valid_reg && advance;
    assign body.ready = !s1_valid_reg || advance;

    always_comb
    begin
        phase_next     = phase_reg;
        hdr_count_next = hdr_count_reg;
        flags_next     = flags_reg;
        remaining_next = remaining_reg;
        kind_next      = kind_reg;
        seen_next      = seen_reg;
        err_next       = err_reg;
        pass           = 1'b0;
        st             = ST_OK;

        if (s1_item_reg.byte_valid && err_reg == ST_OK)
        begin
            if (phase_reg == PH_HEADER)
            begin
                if (hdr_count_reg == 3'd0)
                begin
                    flags_next     = s1_item_reg.byte_value;
                    remaining_next = '0;
                end
                else
                begin
                    remaining_next = {remaining_reg[23:0], s1_item_reg.byte_value};
                end
                hdr_count_next = hdr_count_reg + 3'd1;
                if (hdr_count_reg == 3'(HEADER_BYTES - 1))
                begin
                    // header complete: classify the frame
                    if (flags_reg[FLAG_COMP_BIT])
                        kind_next = KIND_COMPRESSED;
                    else if (flags_reg[FLAG_TRLR_BIT])
                        kind_next = KIND_TRAILER;
                    else if (seen_reg)
                        kind_next = KIND_EXTRA;
                    else
                    begin
                        kind_next = KIND_DATA;
                        seen_next = 1'b1;
                    end
                    hdr_count_next = 3'd0;
                    if (remaining_next == 32'd0)
                    begin
                        // empty payload completes the frame at once
                        if (kind_next == KIND_COMPRESSED)
                            err_next = ST_COMPRESSED;
                        else if (kind_next == KIND_EXTRA)
                            err_next = ST_EXTRA;
                        phase_next = PH_HEADER;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            else
            begin
                pass           = (kind_reg == KIND_DATA);
                remaining_next = remaining_reg - 32'd1;
                if (remaining_next == 32'd0)
                begin
                    if (kind_reg == KIND_COMPRESSED)
                        err_next = ST_COMPRESSED;
                    else if (kind_reg == KIND_EXTRA)
                        err_next = ST_EXTRA;
                    phase_next     = PH_HEADER;
                    hdr_count_next = 3'd0;
                end
            end
        end

        if (s1_item_reg.end_of_body)
        begin
            if (err_next != ST_OK)
                st = err_next;
            else if (phase_next == PH_PAYLOAD)
                st = ST_TRUNC_MESSAGE;
            else if (hdr_count_next != 3'd0)
                st = ST_TRUNC_HEADER;
            else if (!seen_next)
                st = ST_NONE;
            else
                st = ST_OK;
            // next item starts a fresh body
            phase_next     = PH_HEADER;
            hdr_count_next = 3'd0;
            flags_next     = '0;
            remaining_next = '0;
            kind_next      = KIND_DATA;
            seen_next      = 1'b0;
            err_next       = ST_OK;
        end
    end

    always_comb
    begin
        out_item_next.payload_byte  = pass ? s1_item_reg.byte_value : 8'd0;
        out_item_next.payload_valid = pass;
        out_item_next.body_done     = s1_item_reg.end_of_body;
        out_item_next.status        = st;
        out_valid_next              = out_valid_reg && !result.ready;
        if (proc && (pass || s1_item_reg.end_of_body))
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_HEADER;
            hdr_count_reg <= 3'd0;
            flags_reg     <= '0;
            remaining_reg <= '0;
            kind_reg      <= KIND_DATA;
            seen_reg      <= 1'b0;
            err_reg       <= ST_OK;
        end
        else
        begin
            if (body.ready)
                s1_valid_reg <= body.valid;
            out_valid_reg <= out_valid_next;
            if (proc)
            begin
                phase_reg     <= phase_next;
                hdr_count_reg <= hdr_count_next;
                flags_reg     <= flags_next;
                remaining_reg <= remaining_next;
                kind_reg      <= kind_next;
                seen_reg      <= seen_next;
                err_reg       <= err_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (body.ready && body.valid)
            s1_item_reg <= body.data;
        if (proc && (pass || s1_item_reg.end_of_body))
            out_item_reg <= out_item_next;
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_item_reg;

    `GUD_ASSERT_NOW(a_result_not_empty, out_valid_reg,
        out_item_reg.payload_valid || out_item_reg.body_done,
        "result transfer carries neither payload nor end of body")
    `GUD_ASSERT_NOW(a_status_only_at_end, out_valid_reg && !out_item_reg.body_done,
        out_item_reg.status == ST_OK, "status set on a payload-only result")
    `GUD_ASSERT_NOW(a_header_count_range, 1'b1,
        hdr_count_reg < 3'(HEADER_BYTES), "header count past header length")
    `GUD_ASSERT_NEXT(a_body_end_clears, proc && s1_item_reg.end_of_body,
        err_reg == ST_OK && hdr_count_reg == 3'd0 && !seen_reg && phase_reg == PH_HEADER,
        "frame state not cleared after end of body")

endmodule

// File: sim/grpc_unary_deframer_test.sv
`timescale 1ns / 1ps
module grpc_unary_deframer_test;
    import gud_pkg::*;

    logic clk = 1'b0;
    logic rst_n;

    gud_in_if  body_ch ();
    gud_out_if result_ch ();

    grpc_unary_deframer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .body   (body_ch),
        .result (result_ch)
    );

    // 8 ns clock
    always #4 clk = ~clk;

    // idle rates in percent, changed between traffic phases
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    // long result hold-off, counted down by the receiver process
    int unsigned hold_cycles   = 0;

    int unsigned fail_count    = 0;
    int unsigned bytes_sent    = 0;   // transfers carrying a byte or an end marker

    // expected result transfers, oldest first
    out_item_t deframed_q[$];
    out_item_t want;

    // shadow of the deframer's frame state
    phase_t      sh_phase;
    logic [2:0]  sh_hdr_taken;
    logic [7:0]  sh_flags;
    logic [31:0] sh_left;
    kind_t       sh_kind;
    logic        sh_data_seen;
    status_t     sh_sticky;

    function automatic void shadow_clear();
        sh_phase     = PH_HEADER;
        sh_hdr_taken = 3'd0;
        sh_flags     = 8'd0;
        sh_left      = 32'd0;
        sh_kind      = KIND_DATA;
        sh_data_seen = 1'b0;
        sh_sticky    = ST_OK;
    endfunction

    // a frame's error lands when its payload runs out
    function automatic void frame_closed();
        if (sh_kind == KIND_COMPRESSED)
            sh_sticky = ST_COMPRESSED;
        else if (sh_kind == KIND_EXTRA)
            sh_sticky = ST_EXTRA;
        sh_phase     = PH_HEADER;
        sh_hdr_taken = 3'd0;
    endfunction

    // advance the shadow by one accepted body transfer and queue what it yields
    function automatic void deframe_item(input in_item_t it);
        logic      pass;
        status_t   st;
        out_item_t r;
        pass = 1'b0;
        st   = ST_OK;
        // bytes after a sticky error are dropped
        if (it.byte_valid && sh_sticky == ST_OK)
        begin
            if (sh_phase == PH_HEADER)
            begin
                if (sh_hdr_taken == 3'd0)
                begin
                    sh_flags = it.byte_value;
                    sh_left  = 32'd0;
                end
                else
                begin
                    sh_left = {sh_left[23:0], it.byte_value};
                end
                sh_hdr_taken = sh_hdr_taken + 3'd1;
                if (sh_hdr_taken == 3'(HEADER_BYTES))
                begin
                    // compressed bit wins over trailer bit
                    if (sh_flags[FLAG_COMP_BIT])
                        sh_kind = KIND_COMPRESSED;
                    else if (sh_flags[FLAG_TRLR_BIT])
                        sh_kind = KIND_TRAILER;
                    else if (sh_data_seen)
                        sh_kind = KIND_EXTRA;
                    else
                    begin
                        sh_kind      = KIND_DATA;
                        sh_data_seen = 1'b1;
                    end
                    sh_hdr_taken = 3'd0;
                    if (sh_left == 32'd0)
                        frame_closed();
                    else
                        sh_phase = PH_PAYLOAD;
                end
            end
            else
            begin
                pass    = (sh_kind == KIND_DATA);
                sh_left = sh_left - 32'd1;
                if (sh_left == 32'd0)
                    frame_closed();
            end
        end
        if (it.end_of_body)
        begin
            if (sh_sticky != ST_OK)
                st = sh_sticky;
            else if (sh_phase == PH_PAYLOAD)
                st = ST_TRUNC_MESSAGE;
            else if (sh_hdr_taken != 3'd0)
                st = ST_TRUNC_HEADER;
            else if (!sh_data_seen)
                st = ST_NONE;
            else
                st = ST_OK;
            shadow_clear();
        end
        if (pass || it.end_of_body)
        begin
            r.payload_byte  = pass ? it.byte_value : 8'd0;
            r.payload_valid = pass;
            r.body_done     = it.end_of_body;
            r.status        = st;
            deframed_q.insert(deframed_q.size(), r);
        end
    endfunction

    // one body transfer, with a random idle gap in front of it
    task automatic send_item(input logic [7:0] b, input logic bv, input logic eob);
        in_item_t it;
        it.byte_value  = b;
        it.byte_valid  = bv;
        it.end_of_body = eob;
        while ($urandom_range(99) < send_idle_pct)
        begin
            body_ch.valid <= 1'b0;
            @(posedge clk);
        end
        body_ch.valid <= 1'b1;
        body_ch.data  <= it;
        @(posedge clk);
        while (!body_ch.ready)
            @(posedge clk);
        deframe_item(it);
        if (bv || eob)
            bytes_sent++;
    endtask

    task automatic send_header(input logic [7:0] flags, input logic [31:0] len);
        send_item(flags, 1'b1, 1'b0);
        send_item(len[31:24], 1'b1, 1'b0);
        send_item(len[23:16], 1'b1, 1'b0);
        send_item(len[15:8], 1'b1, 1'b0);
        send_item(len[7:0], 1'b1, 1'b0);
    endtask

    // receiver: random ready, or held low while a hold-off runs
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                result_ch.ready <= 1'b0;
                hold_cycles--;
            end
            else
            begin
                result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // every result transfer is matched against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (deframed_q.size() == 0)
            begin
                $error("unexpected result transfer: %p", result_ch.data);
                fail_count++;
            end
            else
            begin
                want = deframed_q.pop_front();
                if (result_ch.data.payload_byte !== want.payload_byte)
                begin
                    $error("payload_byte: expected %0h, got %0h",
                           want.payload_byte, result_ch.data.payload_byte);
                    fail_count++;
                end
                if (result_ch.data.payload_valid !== want.payload_valid)
                begin
                    $error("payload_valid: expected %0b, got %0b",
                           want.payload_valid, result_ch.data.payload_valid);
                    fail_count++;
                end
                if (result_ch.data.body_done !== want.body_done)
                begin
                    $error("body_done: expected %0b, got %0b",
                           want.body_done, result_ch.data.body_done);
                    fail_count++;
                end
                if (result_ch.data.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d",
                           want.status, result_ch.data.status);
                    fail_count++;
                end
            end
        end
    end

    // short bodies for each end-of-body status but extra, and the field extremes
    task automatic test_directed_edges();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // empty transfer does nothing, bare end with no frame gives no message
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'hFF, 1'b0, 1'b1);
        // one data frame of one byte, end rides on the payload byte: ok
        send_header(8'h00, 32'd1);
        send_item(8'hFF, 1'b1, 1'b1);
        // both flag bits set, zero length: compressed is decided at once
        send_header(8'h81, 32'd0);
        send_item(8'h00, 1'b0, 1'b1);
        // end inside the header: truncated header
        send_item(8'h7E, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);
        // trailer with the largest length, cut off: truncated message
        send_header(8'h80, 32'hFFFF_FFFF);
        send_item(8'h00, 1'b1, 1'b1);
    endtask

    // one random body: mostly well-formed frames, sometimes cut short
    task automatic send_random_body();
        logic [7:0]  body_bytes[$];
        logic [7:0]  flags;
        logic [31:0] len;
        int unsigned nframes;
        int unsigned pick;
        int unsigned npay;
        int unsigned cut;
        bit          open_ended;
        bit          end_on_byte;
        pick = $urandom_range(99);
        nframes = (pick < 10) ? 0 : (pick < 55) ? 1 : $urandom_range(2, 3);
        open_ended = 1'b0;
        for (int f = 0; f < nframes && !open_ended; f++)
        begin
            pick  = $urandom_range(99);
            flags = 8'($urandom);
            if (pick < 55)
            begin
                flags[FLAG_COMP_BIT] = 1'b0;
                flags[FLAG_TRLR_BIT] = 1'b0;
            end
            else if (pick < 75)
            begin
                flags[FLAG_COMP_BIT] = 1'b0;
                flags[FLAG_TRLR_BIT] = 1'b1;
            end
            else if (pick < 88)
            begin
                flags[FLAG_COMP_BIT] = 1'b1;
            end
            // huge length: the body can only end inside this payload
            if ($urandom_range(99) < 6)
            begin
                len        = $urandom;
                npay       = $urandom_range(0, 4);
                open_ended = 1'b1;
                if (len < npay)
                    npay = len;
            end
            else
            begin
                len  = ($urandom_range(9) == 0) ? $urandom_range(13, 40)
                                                : $urandom_range(0, 12);
                npay = len;
            end
            body_bytes.insert(body_bytes.size(), flags);
            body_bytes.insert(body_bytes.size(), len[31:24]);
            body_bytes.insert(body_bytes.size(), len[23:16]);
            body_bytes.insert(body_bytes.size(), len[15:8]);
            body_bytes.insert(body_bytes.size(), len[7:0]);
            for (int i = 0; i < npay; i++)
                body_bytes.insert(body_bytes.size(), 8'($urandom));
        end
        // broken bodies: drop a random tail
        if (body_bytes.size() > 0 && $urandom_range(99) < 12)
        begin
            cut = $urandom_range(body_bytes.size() - 1, 0);
            while (body_bytes.size() > cut)
                void'(body_bytes.pop_back());
        end
        end_on_byte = (body_bytes.size() > 0) && ($urandom_range(1) == 1);
        foreach (body_bytes[i])
        begin
            // stray empty transfers between bytes
            if ($urandom_range(99) < 3)
                send_item(8'($urandom), 1'b0, 1'b0);
            send_item(body_bytes[i], 1'b1,
                      end_on_byte && (i == body_bytes.size() - 1));
        end
        if (!end_on_byte)
            send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic test_random_traffic(input int unsigned s_pct, input int unsigned r_pct,
                                       input int unsigned n_items);
        int unsigned start;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        start = bytes_sent;
        while (bytes_sent - start < n_items)
            send_random_body();
    endtask

    // receiver holds off for a long stretch while a long message streams in
    task automatic test_result_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles   = 250;
        send_header(8'h00, 32'd64);
        for (int i = 0; i < 64; i++)
            send_item(8'($urandom), 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
    endtask

    task automatic finish_run();
        int unsigned waited;
        body_ch.valid <= 1'b0;
        waited = 0;
        while (deframed_q.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        // two-stage pipeline, keep watching for stray transfers before the final check
        repeat (10) @(posedge clk);
        if (deframed_q.size() != 0)
        begin
            $error("%0d expected result transfers never arrived", deframed_q.size());
            fail_count++;
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        body_ch.valid = 1'b0;
        body_ch.data  = '0;
        shadow_clear();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        test_random_traffic(14, 55, 620);
        test_result_stall();
        test_random_traffic(55, 14, 620);
        test_random_traffic(0, 0, 620);
        finish_run();

        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
